FILE: rtl/tsep_pkg.sv
// Shared types, constants and the month-offset table for the timestamp
// text to epoch seconds unit. No dependencies.
package tsep_pkg;

    // number of numeric fields in a token: year, month, day, hour, minute, second
    localparam logic [2:0] FIELD_COUNT = 3'd6;
    localparam logic [2:0] FIELD_YEAR = 3'd0;
    localparam logic [2:0] FIELD_MONTH = 3'd1;
    localparam logic [2:0] FIELD_DAY = 3'd2;
    localparam logic [2:0] FIELD_HOUR = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    // separator characters
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [31:0] CHAR_ZERO = 32'd48;

    // date arithmetic constants
    localparam logic [31:0] EPOCH_YEAR = 32'd1970;
    localparam logic [31:0] SEC_PER_DAY = 32'd86400;
    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] SEC_PER_MINUTE = 32'd60;
    localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
    localparam logic [31:0] MONTH_COUNT = 32'd12;
    localparam logic [31:0] LAST_LEAP_MONTH = 32'd2;

    // one input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    // one result item
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        month_invalid;
    } result_t;

    // parsed token passed from the parser to the date unit
    typedef struct packed {
        logic [31:0] year_value;
        logic [31:0] month_value;
        logic [31:0] day_value;
        logic [31:0] hour_value;
        logic [31:0] minute_value;
        logic [31:0] second_value;
    } record_t;

    // date unit sequencer states
    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_BASE,
        BACK_YEARS,
        BACK_DAYS,
        BACK_HOURS,
        BACK_MINUTES,
        BACK_FINISH
    } back_state_t;

    // days before the first of each month in a non-leap year
    function automatic logic [8:0] days_before_month(input logic [3:0] month_index);
        logic [8:0] days;
        begin
            case (month_index)
                4'd0:    days = 9'd0;
                4'd1:    days = 9'd31;
                4'd2:    days = 9'd59;
                4'd3:    days = 9'd90;
                4'd4:    days = 9'd120;
                4'd5:    days = 9'd151;
                4'd6:    days = 9'd181;
                4'd7:    days = 9'd212;
                4'd8:    days = 9'd243;
                4'd9:    days = 9'd273;
                4'd10:   days = 9'd304;
                4'd11:   days = 9'd334;
                default: days = 9'd0;
            endcase
            return days;
        end
    endfunction

endpackage

FILE: rtl/tsep_front.sv
// Character parser: splits the token into six numeric fields and hands a
// complete record to the queue on the last character. Depends on tsep_pkg.
module tsep_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tsep_pkg::char_item_t char_item,
    output logic                rec_push,
    input  logic                rec_full,
    output tsep_pkg::record_t   rec_data
);

    logic [2:0]  field_number_reg, field_number_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] year_reg, year_next;
    logic [31:0] month_reg, month_next;
    logic [31:0] day_reg, day_next;
    logic [31:0] hour_reg, hour_next;
    logic [31:0] minute_reg, minute_next;

    logic        accept;
    logic        is_sep;
    logic [31:0] char_signed;
    logic [2:0]  step_field;
    logic [31:0] step_acc;
    logic [31:0] step_year, step_month, step_day, step_hour, step_minute;

    // the parser only stalls when no queue slot is free
    assign full   = rec_full;
    assign accept = push && !rec_full;

    // separator classification and signed digit value
    assign is_sep = char_item.char_code inside {
        tsep_pkg::CHAR_SPACE, tsep_pkg::CHAR_COLON, tsep_pkg::CHAR_DASH,
        tsep_pkg::CHAR_SLASH, tsep_pkg::CHAR_T, tsep_pkg::CHAR_DOT,
        tsep_pkg::CHAR_LF, tsep_pkg::CHAR_CR};
    assign char_signed = {{24{char_item.char_code[7]}}, char_item.char_code};

    // state after consuming the current character
    always_comb
    begin
        step_field  = field_number_reg;
        step_acc    = acc_reg;
        step_year   = year_reg;
        step_month  = month_reg;
        step_day    = day_reg;
        step_hour   = hour_reg;
        step_minute = minute_reg;
        if (field_number_reg < tsep_pkg::FIELD_COUNT)
        begin
            if (is_sep)
            begin
                if (field_number_reg < tsep_pkg::FIELD_SECOND)
                begin
                    case (field_number_reg)
                        tsep_pkg::FIELD_YEAR:   step_year   = acc_reg;
                        tsep_pkg::FIELD_MONTH:  step_month  = acc_reg;
                        tsep_pkg::FIELD_DAY:    step_day    = acc_reg;
                        tsep_pkg::FIELD_HOUR:   step_hour   = acc_reg;
                        tsep_pkg::FIELD_MINUTE: step_minute = acc_reg;
                        default: ;
                    endcase
                    step_acc = '0;
                end
                step_field = field_number_reg + 3'd1;
            end
            else
            begin
                step_acc = (acc_reg << 3) + (acc_reg << 1) + char_signed
                           - tsep_pkg::CHAR_ZERO;
            end
        end
    end

    // record formed on the last character: the open field is closed
    always_comb
    begin
        rec_data.year_value   = step_year;
        rec_data.month_value  = step_month;
        rec_data.day_value    = step_day;
        rec_data.hour_value   = step_hour;
        rec_data.minute_value = step_minute;
        rec_data.second_value = '0;
        case (step_field)
            tsep_pkg::FIELD_YEAR:   rec_data.year_value   = step_acc;
            tsep_pkg::FIELD_MONTH:  rec_data.month_value  = step_acc;
            tsep_pkg::FIELD_DAY:    rec_data.day_value    = step_acc;
            tsep_pkg::FIELD_HOUR:   rec_data.hour_value   = step_acc;
            tsep_pkg::FIELD_MINUTE: rec_data.minute_value = step_acc;
            default:                rec_data.second_value = step_acc;
        endcase
    end

    assign rec_push = accept && char_item.last_char;

    // next parser state: cleared after the last character
    always_comb
    begin
        field_number_next = field_number_reg;
        acc_next          = acc_reg;
        year_next         = year_reg;
        month_next        = month_reg;
        day_next          = day_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        if (accept)
        begin
            if (char_item.last_char)
            begin
                field_number_next = '0;
                acc_next          = '0;
                year_next         = '0;
                month_next        = '0;
                day_next          = '0;
                hour_next         = '0;
                minute_next       = '0;
            end
            else
            begin
                field_number_next = step_field;
                acc_next          = step_acc;
                year_next         = step_year;
                month_next        = step_month;
                day_next          = step_day;
                hour_next         = step_hour;
                minute_next       = step_minute;
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg <= '0;
            acc_reg          <= '0;
            year_reg         <= '0;
            month_reg        <= '0;
            day_reg          <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
        end
        else
        begin
            field_number_reg <= field_number_next;
            acc_reg          <= acc_next;
            year_reg         <= year_next;
            month_reg        <= month_next;
            day_reg          <= day_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
        end
    end

endmodule

FILE: rtl/tsep_queue.sv
// Two-entry record queue between the parser and the date unit.
// Depends on tsep_pkg.
module tsep_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tsep_pkg::record_t wr_data,
    input  logic              pop,
    output logic              empty,
    output tsep_pkg::record_t rd_data
);

    tsep_pkg::record_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/tsep_back.sv
// Date unit: turns a parsed record into epoch seconds over a short sequence
// of constant multiplies and holds the result for the consumer. Depends on tsep_pkg.
module tsep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tsep_pkg::record_t rec_data,
    input  logic              rec_empty,
    output logic              rec_pop,
    output logic              empty,
    input  logic              pop,
    output tsep_pkg::result_t result
);

    tsep_pkg::back_state_t state_reg, state_next;
    tsep_pkg::record_t     rec_reg;
    tsep_pkg::result_t     result_reg;
    logic                  result_valid_reg, result_valid_next;
    logic [31:0]           acc_reg, acc_next;
    logic [31:0]           tyears_reg;
    logic                  invalid_reg;

    logic        slot_free;
    logic        load_rec;
    logic        load_result;
    logic [31:0] tyears;
    logic [31:0] tyears_plus2;
    logic [31:0] leaps;
    logic [31:0] month_index;
    logic        month_bad;
    logic        leap_adjust;
    logic [31:0] base_days;

    assign slot_free = !result_valid_reg || pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsep_pkg::BACK_IDLE:
            begin
                if (!rec_empty)
                begin
                    state_next = tsep_pkg::BACK_BASE;
                end
            end
            tsep_pkg::BACK_BASE:    state_next = tsep_pkg::BACK_YEARS;
            tsep_pkg::BACK_YEARS:   state_next = tsep_pkg::BACK_DAYS;
            tsep_pkg::BACK_DAYS:    state_next = tsep_pkg::BACK_HOURS;
            tsep_pkg::BACK_HOURS:   state_next = tsep_pkg::BACK_MINUTES;
            tsep_pkg::BACK_MINUTES: state_next = tsep_pkg::BACK_FINISH;
            tsep_pkg::BACK_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = tsep_pkg::BACK_IDLE;
                end
            end
            default: state_next = tsep_pkg::BACK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        load_rec    = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            tsep_pkg::BACK_IDLE:   load_rec    = !rec_empty;
            tsep_pkg::BACK_FINISH: load_result = slot_free;
            default: ;
        endcase
    end

    assign rec_pop = load_rec;

    // day count before the year term
    always_comb
    begin
        tyears       = rec_reg.year_value - tsep_pkg::EPOCH_YEAR;
        tyears_plus2 = tyears + 32'd2;
        leaps        = tyears_plus2 >> 2;
        month_index  = rec_reg.month_value - 32'd1;
        month_bad    = (month_index >= tsep_pkg::MONTH_COUNT);
        leap_adjust  = (rec_reg.month_value <= tsep_pkg::LAST_LEAP_MONTH)
                       && (tyears_plus2[1:0] == 2'b00);
        base_days    = {23'd0, tsep_pkg::days_before_month(month_index[3:0])}
                       + rec_reg.day_value - 32'd1 + leaps
                       - {31'd0, leap_adjust};
    end

    // accumulator: at most one constant multiply per step
    always_comb
    begin
        acc_next = acc_reg;
        case (state_reg)
            tsep_pkg::BACK_BASE:    acc_next = base_days;
            tsep_pkg::BACK_YEARS:
                acc_next = acc_reg + 32'(tyears_reg * tsep_pkg::DAYS_PER_YEAR);
            tsep_pkg::BACK_DAYS:
                acc_next = 32'(acc_reg * tsep_pkg::SEC_PER_DAY);
            tsep_pkg::BACK_HOURS:
                acc_next = acc_reg + 32'(rec_reg.hour_value * tsep_pkg::SEC_PER_HOUR);
            tsep_pkg::BACK_MINUTES:
                acc_next = acc_reg
                           + 32'(rec_reg.minute_value * tsep_pkg::SEC_PER_MINUTE)
                           + rec_reg.second_value;
            default: ;
        endcase
    end

    // result slot valid flag
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (pop)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tsep_pkg::BACK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load_rec)
        begin
            rec_reg <= rec_data;
        end
        if (state_reg == tsep_pkg::BACK_BASE)
        begin
            tyears_reg  <= tyears;
            invalid_reg <= month_bad;
        end
        if (load_result)
        begin
            result_reg.epoch_seconds <= invalid_reg ? 32'd0 : acc_reg;
            result_reg.month_invalid <= invalid_reg;
        end
    end

    assign empty  = !result_valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/timestamp_text_to_epoch_seconds_unit.sv
// Timestamp text to epoch seconds unit: parser, record queue and date unit.
// Depends on tsep_pkg, tsep_front, tsep_queue and tsep_back.
//
// Usage:
//   Input channel: one character item per cycle with push; an item is taken
//   when push is high and full is low. last_char marks the final character of
//   a token; each token produces exactly one result item.
//   Result channel: while empty is low, result holds the oldest result; it is
//   taken when pop is high and empty is low.
// Flow:
//   The parser takes one character per cycle while full is low. A finished
//   token is queued (two entries); the date unit takes one token at a time
//   through its idle, base, years, days, hours, minutes and finish states,
//   at most one constant multiply per step. Tokens arriving faster than the
//   date unit finishes them fill the queue, and full rises until it drains.
// Reset: rst_n clears the parser state, the queue and the result slot.
// Stalls:
//   While the result is not popped, the date unit holds its next result and
//   stops draining the queue; the parser keeps taking characters until the
//   queue is full.
module timestamp_text_to_epoch_seconds_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tsep_pkg::char_item_t char_item,
    output logic                 empty,
    input  logic                 pop,
    output tsep_pkg::result_t    result
);

    tsep_pkg::record_t front_rec;
    tsep_pkg::record_t queue_rec;
    logic              rec_push;
    logic              rec_full;
    logic              rec_pop;
    logic              rec_empty;

    tsep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .rec_push  (rec_push),
        .rec_full  (rec_full),
        .rec_data  (front_rec)
    );

    tsep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rec_push),
        .full    (rec_full),
        .wr_data (front_rec),
        .pop     (rec_pop),
        .empty   (rec_empty),
        .rd_data (queue_rec)
    );

    tsep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_data  (queue_rec),
        .rec_empty (rec_empty),
        .rec_pop   (rec_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
